FILE: design/fpba_pkg.sv
// fpba_pkg: shared sizes, codes and control types of the fit-policy block allocator
// used by fpba_ctrl, fpba_dp and fit_policy_block_allocator_top
`timescale 1ns / 1ps

package fpba_pkg;

    localparam int NUM_BLOCKS = 8;
    localparam int SIZE_WIDTH = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // fixed field widths of the stream beats
    localparam int OP_W     = 1;
    localparam int BLK_W    = 3;
    localparam int AMT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int POL_W    = 2;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b1;

    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_LOADED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } fpba_state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic commit;
    } fpba_cmd_t;

    typedef struct packed {
        logic in_alloc;
        logic scan_last;
    } fpba_sts_t;

endpackage

FILE: design/fpba_ctrl.sv
// fpba_ctrl: sequencer of the allocator, steps capture, table scan and commit
// depends on fpba_pkg; drives fpba_dp through fpba_cmd_t
`timescale 1ns / 1ps

module fpba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  fpba_pkg::fpba_sts_t sts,
    output fpba_pkg::fpba_cmd_t cmd
);
    import fpba_pkg::*;

    fpba_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    // result slot can take a new beat this cycle
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.in_alloc ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                // last table entry is compared in this cycle
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/fpba_dp.sv
// fpba_dp: capacity table, policy register, scan compare and result register
// depends on fpba_pkg; controlled by fpba_ctrl
`timescale 1ns / 1ps

module fpba_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [fpba_pkg::POL_W-1:0]      cfg_data,
    input  logic [fpba_pkg::OP_W-1:0]       s_tuser,
    input  logic [fpba_pkg::S_DATA_W-1:0]   s_tdata,
    input  fpba_pkg::fpba_cmd_t             cmd,
    output fpba_pkg::fpba_sts_t             sts,
    output logic [fpba_pkg::STATUS_W-1:0]   m_tuser,
    output logic [fpba_pkg::M_DATA_W-1:0]   m_tdata
);
    import fpba_pkg::*;

    logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;

    logic [POL_W-1:0]      policy_reg;
    logic [OP_W-1:0]       op_reg;
    logic [BLK_W-1:0]      idx_reg;
    logic [SIZE_WIDTH-1:0] amt_reg;

    logic [IDX_W-1:0]      scan_idx_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [SIZE_WIDTH-1:0] rd_raw_reg;
    logic                  rd_hit_reg;

    logic                  found_reg;
    logic [IDX_W-1:0]      sel_idx_reg;
    logic [SIZE_WIDTH-1:0] sel_cap_reg;

    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [BLK_W-1:0]      res_blk_reg, res_blk_next;
    logic [AMT_W-1:0]      res_cap_reg, res_cap_next;

    logic [SIZE_WIDTH-1:0] rd_cap;
    logic                  take;
    logic                  load_in_range;
    logic [SIZE_WIDTH-1:0] alloc_left;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [SIZE_WIDTH-1:0] wr_data;

    assign sts.in_alloc  = (s_tuser == OP_ALLOC);
    assign sts.scan_last = (scan_idx_reg == IDX_W'(NUM_BLOCKS - 1));

    // never-loaded entries read as zero capacity
    assign rd_cap = rd_hit_reg ? rd_raw_reg : '0;
    assign take   = rd_vld_reg && (rd_cap >= amt_reg) &&
                    (!found_reg ||
                     ((policy_reg == POL_BEST)  && (rd_cap < sel_cap_reg)) ||
                     ((policy_reg == POL_WORST) && (rd_cap > sel_cap_reg)));

    assign load_in_range = (32'(idx_reg) < 32'(NUM_BLOCKS));
    assign alloc_left    = sel_cap_reg - amt_reg;

    assign wr_en   = cmd.commit && (((op_reg == OP_LOAD) && load_in_range) ||
                                    ((op_reg == OP_ALLOC) && found_reg));
    assign wr_addr = (op_reg == OP_LOAD) ? IDX_W'(idx_reg) : sel_idx_reg;
    assign wr_data = (op_reg == OP_LOAD) ? amt_reg : alloc_left;

    always_comb
    begin
        res_status_next = ST_NONE;
        res_blk_next    = '0;
        res_cap_next    = '0;
        if (op_reg == OP_LOAD)
        begin
            res_status_next = ST_LOADED;
            res_blk_next    = idx_reg;
            res_cap_next    = load_in_range ? AMT_W'(amt_reg) : '0;
        end
        else if (found_reg)
        begin
            res_status_next = ST_ALLOC;
            res_blk_next    = BLK_W'(sel_idx_reg);
            res_cap_next    = AMT_W'(alloc_left);
        end
    end

    // table storage, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.scan_step)
        begin
            rd_raw_reg <= mem[scan_idx_reg];
            rd_hit_reg <= valid_reg[scan_idx_reg];
            rd_idx_reg <= scan_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            policy_reg   <= POL_FIRST;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (cfg_valid)
                policy_reg <= cfg_data;
            rd_vld_reg <= cmd.scan_step;
            if (cmd.capture)
            begin
                found_reg    <= 1'b0;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (take)
                    found_reg <= 1'b1;
                if (cmd.scan_step && !sts.scan_last)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= s_tuser;
            idx_reg <= s_tdata[BLK_W-1:0];
            amt_reg <= SIZE_WIDTH'(s_tdata[BLK_W +: AMT_W]);
        end
        if (take)
        begin
            sel_idx_reg <= rd_idx_reg;
            sel_cap_reg <= rd_cap;
        end
        if (cmd.commit)
        begin
            res_status_reg <= res_status_next;
            res_blk_reg    <= res_blk_next;
            res_cap_reg    <= res_cap_next;
        end
    end

    assign m_tuser = res_status_reg;
    assign m_tdata = {{(M_DATA_W - BLK_W - AMT_W){1'b0}}, res_cap_reg, res_blk_reg};

endmodule

FILE: design/fit_policy_block_allocator_top.sv
// fit_policy_block_allocator_top: stream wrapper joining sequencer and datapath
// depends on fpba_pkg, fpba_ctrl and fpba_dp
`timescale 1ns / 1ps

// Keeps the free capacity of NUM_BLOCKS memory blocks and places allocation requests by a
// first, best or worst fit policy (cfg_data: 0 first, 1 best, 2 worst, 3 first). A load beat
// (s_tuser 0) goes from idle to the commit state, which registers its result and raises
// m_tvalid. An allocate beat (s_tuser 1) scans the table one entry per cycle through its
// single read port, compares the last entry from the read register in the drain state and
// then commits its result the same way. One item is in work at a time; the next beat can be
// taken once the block is back in idle, which it enters as the result is registered. A new
// beat is taken even while the previous result still waits on m_tready, but its own result
// then waits until that beat leaves. Ties go to the lowest block index. The table is clear
// (all zero) straight after reset; write the policy only while the block is idle.
module fit_policy_block_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,   // fit_policy
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // block_index [2:0], amount [18:3], zero fill
    input  logic [0:0]  s_tuser,    // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // chosen_block [2:0], capacity_left [18:3], zero fill
    output logic [1:0]  m_tuser     // status
);
    import fpba_pkg::*;

    fpba_cmd_t cmd;
    fpba_sts_t sts;

    assign cfg_ready = 1'b1;

    fpba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in work");

    // a failed allocation reports block zero with no capacity
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_NONE)) |-> (m_tdata[18:0] == 19'd0))
        else $error("not-allocated result carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ST_LOADED) || (m_tuser == ST_ALLOC) || (m_tuser == ST_NONE)))
        else $error("undefined status code");

    // a commit always leaves a result waiting
    a_commit_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("commit without a result beat");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking stream testbench for fit_policy_block_allocator_top
// depends on fpba_pkg and the allocator rtl; the free-capacity table is predicted in the bench
`timescale 1ns / 1ps

module tb_top;

    import fpba_pkg::*;

    localparam logic [POL_W-1:0] POL_FIRST_ALT = 2'd3;  // spare code, behaves as first fit
    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_ITEMS   = 210;
    localparam int NUM_PHASES    = 8;
    localparam int HOLD_START    = 4000;
    localparam int HOLD_END      = 4400;
    localparam int BUSY_START    = 10000;
    localparam int BUSY_END      = 14000;

    typedef enum logic { ROW_BEAT, ROW_POLICY } row_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    blk;
        logic [AMT_W-1:0]    cap;
    } alloc_result_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [OP_W-1:0]     op;
        logic [BLK_W-1:0]    idx;
        logic [AMT_W-1:0]    amt;
        logic [POL_W-1:0]    pol;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    blk;
        logic [AMT_W-1:0]    cap;
    } dir_row_t;

    localparam int NUM_DIR = 21;
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // zero-size request on a clear table takes block 0, a size of one finds nothing
        '{ROW_BEAT, OP_ALLOC, 3'd0, 16'd0,     POL_FIRST, 1'b1, ST_ALLOC,  3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd5, 16'd1,     POL_FIRST, 1'b1, ST_NONE,   3'd0, 16'd0},
        '{ROW_BEAT, OP_LOAD,  3'd0, 16'hFFFF,  POL_FIRST, 1'b1, ST_LOADED, 3'd0, 16'hFFFF},
        '{ROW_BEAT, OP_LOAD,  3'd1, 16'd100,   POL_FIRST, 1'b1, ST_LOADED, 3'd1, 16'd100},
        '{ROW_BEAT, OP_LOAD,  3'd2, 16'd50,    POL_FIRST, 1'b1, ST_LOADED, 3'd2, 16'd50},
        '{ROW_BEAT, OP_LOAD,  3'd3, 16'hAAAA,  POL_FIRST, 1'b1, ST_LOADED, 3'd3, 16'hAAAA},
        '{ROW_BEAT, OP_LOAD,  3'd4, 16'd50,    POL_FIRST, 1'b1, ST_LOADED, 3'd4, 16'd50},
        '{ROW_BEAT, OP_LOAD,  3'd5, 16'h5555,  POL_FIRST, 1'b1, ST_LOADED, 3'd5, 16'h5555},
        '{ROW_BEAT, OP_LOAD,  3'd6, 16'd300,   POL_FIRST, 1'b1, ST_LOADED, 3'd6, 16'd300},
        '{ROW_BEAT, OP_LOAD,  3'd7, 16'd1,     POL_FIRST, 1'b1, ST_LOADED, 3'd7, 16'd1},
        '{ROW_BEAT, OP_ALLOC, 3'd7, 16'hFFFF,  POL_FIRST, 1'b1, ST_ALLOC,  3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd2, 16'd40,    POL_FIRST, 1'b1, ST_ALLOC,  3'd1, 16'd60},
        '{ROW_POLICY, OP_LOAD, 3'd0, 16'd0,    POL_BEST,  1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd0, 16'd45,    POL_BEST,  1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd4, 16'd0,     POL_BEST,  1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_POLICY, OP_LOAD, 3'd0, 16'd0,    POL_WORST, 1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd1, 16'd10,    POL_WORST, 1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd6, 16'hFFFF,  POL_WORST, 1'b1, ST_NONE,   3'd0, 16'd0},
        '{ROW_POLICY, OP_LOAD, 3'd0, 16'd0,    POL_FIRST_ALT, 1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd3, 16'd55,    POL_FIRST_ALT, 1'b0, ST_LOADED, 3'd0, 16'd0},
        '{ROW_BEAT, OP_ALLOC, 3'd0, 16'd1,     POL_FIRST_ALT, 1'b0, ST_LOADED, 3'd0, 16'd0}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [POL_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;

    // bench copy of the allocator state
    logic [AMT_W-1:0]    free_cap [NUM_BLOCKS];
    logic [POL_W-1:0]    fit_policy;
    alloc_result_t       pending_results [$];
    alloc_result_t       got_res;
    alloc_result_t       want_res;

    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;
    int unsigned n_loads      = 0;
    int unsigned n_hits       = 0;
    int unsigned n_misses     = 0;
    int unsigned n_checked    = 0;
    int unsigned stall_cycles = 0;
    int unsigned policy_seen  = 0;
    bit          sender_busy  = 1'b0;

    fit_policy_block_allocator_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit, %0d results still due",
                     $time, pending_results.size());
            $display("fit_policy_block_allocator_top regression: fail");
            $finish;
        end
    end

    // load writes one entry; allocation scans by the current fit policy, ties to lowest index
    function automatic alloc_result_t load_or_place(logic [OP_W-1:0] op, logic [BLK_W-1:0] idx,
                                                    logic [AMT_W-1:0] amt);
        alloc_result_t r;
        int            sel;
        r   = '0;
        sel = -1;
        if (op == OP_LOAD)
        begin
            free_cap[idx] = amt;
            r.status      = ST_LOADED;
            r.blk         = idx;
            r.cap         = amt;
        end
        else
        begin
            for (int j = 0; j < NUM_BLOCKS; j++)
            begin
                if (free_cap[j] >= amt)
                begin
                    if (sel < 0)
                    begin
                        sel = j;
                        if (fit_policy != POL_BEST && fit_policy != POL_WORST)
                            break;
                    end
                    else if (fit_policy == POL_BEST && free_cap[j] < free_cap[sel])
                        sel = j;
                    else if (fit_policy == POL_WORST && free_cap[j] > free_cap[sel])
                        sel = j;
                end
            end
            if (sel < 0)
                r.status = ST_NONE;
            else
            begin
                free_cap[sel] = free_cap[sel] - amt;
                r.status      = ST_ALLOC;
                r.blk         = sel[BLK_W-1:0];
                r.cap         = free_cap[sel];
            end
        end
        return r;
    endfunction

    // offers one beat and waits for it to be taken; a typed row overrides the prediction
    task automatic send_beat(logic [OP_W-1:0] op, logic [BLK_W-1:0] idx, logic [AMT_W-1:0] amt,
                             bit typed, alloc_result_t typed_res);
        alloc_result_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, amt, idx};
        do
            @(posedge clk);
        while (!s_tready);
        r = load_or_place(op, idx, amt);
        if (typed)
            r = typed_res;
        pending_results.push_back(r);
        if (op == OP_LOAD)
            n_loads++;
        else if (r.status == ST_ALLOC)
            n_hits++;
        else
            n_misses++;
    endtask

    task automatic sender_gap(bit may_idle);
        if (may_idle && $urandom_range(0, 99) < 31)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_policy(logic [POL_W-1:0] pol);
        cfg_valid <= 1'b1;
        cfg_data  <= pol;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        fit_policy  = pol;
        policy_seen |= (1 << pol);
    endtask

    function automatic logic [AMT_W-1:0] pick_capacity();
        logic [AMT_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 16'd16 << $urandom_range(0, 3);  // few values, plenty of ties
            4, 5, 6:    v = AMT_W'($urandom_range(0, 1023));
            7, 8:       v = AMT_W'($urandom);
            default:    v = 16'hFFFF;
        endcase
        return v;
    endfunction

    function automatic logic [AMT_W-1:0] pick_request();
        logic [AMT_W-1:0] v;
        case ($urandom_range(0, 9))
            0:             v = 16'd0;
            1, 2, 3, 4, 5: v = AMT_W'($urandom_range(1, 64));
            6, 7:          v = AMT_W'($urandom_range(0, 1023));
            8:             v = AMT_W'($urandom);
            default:       v = 16'hFFFF;
        endcase
        return v;
    endfunction

    // receiver: random back-pressure, one long hold-off and one stretch always ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (cycle_count >= HOLD_START && cycle_count < HOLD_END)
            m_tready <= 1'b0;
        else if (cycle_count >= BUSY_START && cycle_count < BUSY_END)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 31);
    end

    always @(posedge clk)
    begin
        if (s_tvalid && !s_tready)
            stall_cycles <= stall_cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = '{status: m_tuser, blk: m_tdata[2:0], cap: m_tdata[18:3]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat status %0d block %0d capacity %0d",
                         $time, got_res.status, got_res.blk, got_res.cap);
                mismatches++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                n_checked++;
                if (got_res.status !== want_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_res.status, got_res.status);
                    mismatches++;
                end
                if (got_res.blk !== want_res.blk)
                begin
                    $display("%0t: chosen_block expected %0d actual %0d",
                             $time, want_res.blk, got_res.blk);
                    mismatches++;
                end
                if (got_res.cap !== want_res.cap)
                begin
                    $display("%0t: capacity_left expected %0d actual %0d",
                             $time, want_res.cap, got_res.cap);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [POL_W-1:0] phase_pol [NUM_PHASES];
        dir_row_t         row;
        alloc_result_t    typed_res;
        bit               may_idle;

        phase_pol = '{POL_BEST, POL_WORST, POL_FIRST_ALT, POL_FIRST, POL_WORST, POL_BEST,
                      POL_FIRST, POL_BEST};
        fit_policy = POL_FIRST;
        foreach (free_cap[i])
            free_cap[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_DIR; r++)
        begin
            row = DIR_ROWS[r];
            if (row.kind == ROW_POLICY)
            begin
                drain_results();
                write_policy(row.pol);
            end
            else
            begin
                typed_res = '{status: row.status, blk: row.blk, cap: row.cap};
                send_beat(row.op, row.idx, row.amt, row.typed, typed_res);
                sender_gap(1'b1);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            write_policy((p < 6) ? phase_pol[p] : POL_W'($urandom_range(0, 3)));
            may_idle = (p != 3);
            // refill the table so that the allocations that follow mostly land
            for (int b = 0; b < NUM_BLOCKS; b++)
            begin
                send_beat(OP_LOAD, b[BLK_W-1:0], pick_capacity(), 1'b0, '0);
                sender_gap(may_idle);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 30)
                    send_beat(OP_LOAD, BLK_W'($urandom_range(0, 7)), pick_capacity(),
                              1'b0, '0);
                else
                    send_beat(OP_ALLOC, BLK_W'($urandom_range(0, 7)), pick_request(),
                              1'b0, '0);
                sender_gap(may_idle);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads, %0d allocations placed, %0d refused, policy codes seen %b",
                 n_loads, n_hits, n_misses, policy_seen[3:0]);
        $display("%0d result beats checked, %0d cycles with the input stalled",
                 n_checked, stall_cycles);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("fit_policy_block_allocator_top regression: pass");
        else
            $display("fit_policy_block_allocator_top regression: fail");
        $finish;
    end

endmodule
